/* rtl/b32td_pkg.sv */
// ----------------------------------------------------------------------------
// Base32 tolerant decoder package
// Transfer types shared by the decoder and its checkers, and the character
// classification function used by the decoder.
// ----------------------------------------------------------------------------
package b32td_pkg;

  // One input transfer: a raw character and the end-of-string mark.
  typedef struct packed {
    logic [7:0] char_in;
    logic       last_char;
  } in_t;

  // One result transfer.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       decode_error;
    logic       end_of_string;
  } out_t;

  typedef enum logic [1:0] {
    CHAR_SYMBOL,
    CHAR_SKIP,
    CHAR_INVALID
  } char_kind_e;

  typedef struct packed {
    char_kind_e kind;
    logic [4:0] value;
  } char_class_t;

  localparam logic [7:0] ChNbsp   = 8'hA0;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChPad    = 8'h3D;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChUpperO = 8'h4F;
  localparam logic [7:0] ChOne    = 8'h31;
  localparam logic [7:0] ChUpperL = 8'h4C;
  localparam logic [7:0] ChEight  = 8'h38;
  localparam logic [7:0] ChUpperB = 8'h42;

  localparam logic [3:0] AccBits  = 4'd12;
  localparam logic [3:0] ByteBits = 4'd8;

  // Classifies one character after mistype repair and returns its 5-bit value.
  function automatic char_class_t classify_char(logic [7:0] c);
    char_class_t res;
    logic [7:0]  fixed;
    res.kind  = CHAR_INVALID;
    res.value = '0;
    case (c)
      ChZero:  fixed = ChUpperO;
      ChOne:   fixed = ChUpperL;
      ChEight: fixed = ChUpperB;
      default: fixed = c;
    endcase
    case (c)
      ChNbsp, ChTab, ChLf, ChCr, ChPad: res.kind = CHAR_SKIP;
      default: begin
        if (fixed inside {[8'h41:8'h5A], [8'h61:8'h7A]}) begin
          res.kind  = CHAR_SYMBOL;
          res.value = fixed[4:0] - 5'd1;
        end else if (fixed inside {[8'h32:8'h37]}) begin
          res.kind  = CHAR_SYMBOL;
          res.value = fixed[4:0] + 5'd8;
        end
      end
    endcase
    return res;
  endfunction

endpackage

/* rtl/base32_tolerant_decoder.sv */
// ----------------------------------------------------------------------------
// Base32 tolerant decoder
// Decodes base32 characters into bytes, one character a cycle while ready.
// ----------------------------------------------------------------------------
// The decoder takes one character per transfer and can accept a new one in
// every clock cycle while in_ready_o is high, and every result is registered
// before it shows on the output. Only a character that completes a byte, or
// the character marked last, produces a result transfer; skipped characters,
// invalid characters and symbols that do not yet fill a byte are absorbed
// silently. Tab, LF, CR, '=' and 0xA0 are skipped, and '0', '1' and '8' are
// read as 'O', 'L' and 'B'. An invalid character sets decode_error for the
// rest of the string and every later character up to the last one is
// dropped; bytes already sent cannot be recalled, so the consumer must watch
// the flag. The last character always gives a result with end_of_string set,
// leftover bits are discarded and the decoder starts clean on the next
// string. Stalls are absorbed by the output register and a one-entry skid
// register behind it: the input stays ready until both are full, which
// happens when the consumer holds off out_ready_i while a result is
// waiting and another character produces a result; the input then stays
// blocked until the consumer takes the waiting result.
// ----------------------------------------------------------------------------
module base32_tolerant_decoder (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  b32td_pkg::in_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output b32td_pkg::out_t  out_data_o
);
  import b32td_pkg::*;

  // Decoder state.
  logic [11:0] acc_q, acc_d;
  logic [3:0]  bits_q, bits_d;
  logic        err_q, err_d;

  // Output register and skid register.
  out_t out_q, out_d;
  logic out_valid_q, out_valid_d;
  out_t skid_q, skid_d;
  logic skid_valid_q, skid_valid_d;

  logic        in_fire;
  logic        pop;
  char_class_t cls;
  logic [11:0] acc_shift;
  logic [4:0]  bits_sum;
  logic [3:0]  bits_sat;
  logic [2:0]  byte_pos;
  logic [11:0] acc_aligned;
  logic        have_byte;
  logic        err_now;
  logic        res_valid;
  out_t        res;

  // The skid register is free whenever it is empty, so a new character is
  // taken even while the output register waits for the consumer.
  assign in_ready_o  = !skid_valid_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign pop         = out_valid_q && out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Per-character decode: classify, shift five bits in, and pull out a byte
  // once eight or more bits are held.
  always_comb begin
    cls         = classify_char(in_data_i.char_in);
    acc_shift   = {acc_q[6:0], cls.value};
    bits_sum    = {1'b0, bits_q} + 5'd5;
    bits_sat    = (bits_sum > {1'b0, AccBits}) ? AccBits : bits_sum[3:0];
    byte_pos    = 3'(bits_sat - ByteBits);
    acc_aligned = acc_shift >> byte_pos;
    have_byte   = !err_q && (cls.kind == CHAR_SYMBOL) && (bits_sat >= ByteBits);
    err_now     = err_q || (cls.kind == CHAR_INVALID);

    acc_d  = acc_q;
    bits_d = bits_q;
    err_d  = err_q;
    if (in_fire) begin
      if (!err_q) begin
        case (cls.kind)
          CHAR_INVALID: err_d = 1'b1;
          CHAR_SYMBOL: begin
            acc_d  = acc_shift;
            bits_d = have_byte ? (bits_sat - ByteBits) : bits_sat;
          end
          default: ;
        endcase
      end
      // The end of a string clears everything, leftover bits included.
      if (in_data_i.last_char) begin
        acc_d  = '0;
        bits_d = '0;
        err_d  = 1'b0;
      end
    end

    res_valid         = have_byte || in_data_i.last_char;
    res.data_byte     = have_byte ? acc_aligned[7:0] : 8'h00;
    res.byte_valid    = have_byte;
    res.decode_error  = err_now;
    res.end_of_string = in_data_i.last_char;
  end

  // Output register with skid: the skid entry always holds the younger
  // result, and it moves forward as soon as the output register drains.
  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    if (pop) begin
      out_valid_d = 1'b0;
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end
    end
    if (in_fire && res_valid) begin
      if (!out_valid_d) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q        <= '0;
      bits_q       <= '0;
      err_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      acc_q        <= acc_d;
      bits_q       <= bits_d;
      err_q        <= err_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule

/* rtl/b32td_checker.sv */
// ----------------------------------------------------------------------------
// Base32 tolerant decoder checker
// Port-level assertions on the decoder, attached by a bind statement.
// ----------------------------------------------------------------------------
module b32td_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input b32td_pkg::in_t   in_data_i,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input b32td_pkg::out_t  out_data_o
);
  import b32td_pkg::*;

  // A stalled result holds its valid and its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // Input backpressure only appears when a result is already waiting.
  a_ready_low_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input not ready with no pending result");

  // A result without a byte exists only to carry the end mark.
  a_no_byte_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.byte_valid |-> out_data_o.end_of_string)
    else $error("empty result without end of string");

  // Without a byte the data field reads as zero.
  a_no_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.byte_valid |-> out_data_o.data_byte == 8'h00)
    else $error("data byte nonzero without byte_valid");

endmodule

bind base32_tolerant_decoder b32td_checker u_b32td_checker (.*);

/* test/b32td_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Base32 decoder result checker
// Watches both channels of the decoder, predicts the result of every accepted
// character and compares each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module b32td_result_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  b32td_pkg::in_t  in_data_i,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  b32td_pkg::out_t out_data_i,
  output int              mismatch_count_o,
  output int              pending_o
);
  import b32td_pkg::*;

  localparam int         ReportLimit = 10;
  localparam logic [7:0] ChUpperA    = 8'h41;
  localparam logic [7:0] ChUpperZ    = 8'h5A;
  localparam logic [7:0] ChLowerA    = 8'h61;
  localparam logic [7:0] ChLowerZ    = 8'h7A;
  localparam logic [7:0] ChTwo       = 8'h32;
  localparam logic [7:0] ChSeven     = 8'h37;

  // Predicted decoder state.
  logic [11:0] shift_bits;
  logic [3:0]  held_bits;
  logic        string_failed;

  out_t decoded_q[$];
  int   mismatches = 0;

  // Updates the predicted state with one character and queues the result it
  // gives, if any.
  task automatic decode_char(input in_t item);
    logic [7:0] ch;
    logic [4:0] sym;
    logic       is_sym;
    out_t       res;
    res    = '0;
    ch     = item.char_in;
    is_sym = 1'b0;
    sym    = '0;
    if (!string_failed && !(item.char_in inside {ChNbsp, ChTab, ChLf, ChCr, ChPad})) begin
      case (ch)
        ChZero:  ch = ChUpperO;
        ChOne:   ch = ChUpperL;
        ChEight: ch = ChUpperB;
        default: ;
      endcase
      is_sym = 1'b1;
      if (ch >= ChUpperA && ch <= ChUpperZ) begin
        sym = 5'(ch - ChUpperA);
      end else if (ch >= ChLowerA && ch <= ChLowerZ) begin
        sym = 5'(ch - ChLowerA);
      end else if (ch >= ChTwo && ch <= ChSeven) begin
        sym = 5'(ch - ChTwo + 8'd26);
      end else begin
        is_sym        = 1'b0;
        string_failed = 1'b1;
      end
    end
    if (is_sym) begin
      shift_bits = {shift_bits[6:0], sym};
      held_bits  = held_bits + 4'd5;
      if (held_bits >= 4'd8) begin
        res.data_byte  = 8'(shift_bits >> (held_bits - 4'd8));
        res.byte_valid = 1'b1;
        held_bits      = held_bits - 4'd8;
      end
    end
    if (res.byte_valid || item.last_char) begin
      res.decode_error  = string_failed;
      res.end_of_string = item.last_char;
      decoded_q.push_back(res);
    end
    if (item.last_char) begin
      shift_bits    = '0;
      held_bits     = '0;
      string_failed = 1'b0;
    end
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    if (decoded_q.size() == 0) begin
      mismatches++;
      if (mismatches <= ReportLimit) begin
        $display("%0t: result with none expected: byte=%02h valid=%b err=%b end=%b",
                 $time, got.data_byte, got.byte_valid, got.decode_error,
                 got.end_of_string);
      end
    end else begin
      want = decoded_q.pop_front();
      if (got.data_byte !== want.data_byte || got.byte_valid !== want.byte_valid ||
          got.decode_error !== want.decode_error ||
          got.end_of_string !== want.end_of_string) begin
        mismatches++;
        if (mismatches <= ReportLimit) begin
          $display({"%0t: expected byte=%02h valid=%b err=%b end=%b,",
                    " got byte=%02h valid=%b err=%b end=%b"},
                   $time, want.data_byte, want.byte_valid, want.decode_error,
                   want.end_of_string, got.data_byte, got.byte_valid,
                   got.decode_error, got.end_of_string);
        end
      end
    end
  endtask

  // Results are taken before the character of the same edge, since the
  // decoder registers every result before it shows it on the output.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_bits    = '0;
      held_bits     = '0;
      string_failed = 1'b0;
      decoded_q.delete();
      pending_o        <= 0;
      mismatch_count_o <= mismatches;
    end else begin
      if (out_valid_i && out_ready_i) begin
        check_result(out_data_i);
      end
      if (in_valid_i && in_ready_i) begin
        decode_char(in_data_i);
      end
      pending_o        <= decoded_q.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

/* test/tb_base32_tolerant_decoder.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Base32 tolerant decoder testbench
// Feeds directed and random base32 strings to the decoder with random idle
// cycles on both channels and lets the checker compare every result.
// ----------------------------------------------------------------------------
module tb_base32_tolerant_decoder;
  import b32td_pkg::*;

  // Number of random characters after which no new string is started.
  localparam int RandomItems = 1650;
  // Cycles without any transfer before the run is declared hung. The longest
  // correct stretch comes from idle cycles on both sides that fall together.
  localparam int IdleLimit   = 2000;
  // Cycles waited after the last expected result, to catch a stray one.
  localparam int TailCycles  = 8;
  // Share of cycles, in percent, in which each side idles.
  localparam int IdlePercent = 32;

  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChTwo    = 8'h32;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  int   mismatch_count;
  int   results_pending;
  int   idle_cycles = 0;
  int   counted_items = 0;
  // While set, neither side idles.
  logic steady = 1'b0;

  always #5 clk = ~clk;

  base32_tolerant_decoder uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  b32td_result_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_data_i       (out_data),
    .mismatch_count_o (mismatch_count),
    .pending_o        (results_pending)
  );

  // The consumer stalls at random, so that back pressure reaches the skid
  // register and the input side at every point of a string.
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= IdlePercent);
  end

  // Watchdog: a run in which nothing moves for too long has hung.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("base32_tolerant_decoder: mismatch");
      $finish;
    end
  end

  // Offers one character and returns right after the edge at which it was
  // transferred. Valid is lowered only during an idle gap, so it is never
  // dropped and raised within one time step.
  task automatic send_char(input logic [7:0] ch, input logic last);
    while (!steady && $urandom_range(99) < IdlePercent) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{char_in: ch, last_char: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stops the sender until the decoder has delivered everything predicted.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
  endtask

  // A valid alphabet character, now and then one of the repaired mistypes.
  function automatic logic [7:0] pick_symbol();
    int r;
    r = $urandom_range(60);
    if (r < 26) return ChUpperA + 8'(r);
    if (r < 52) return ChLowerA + 8'(r - 26);
    if (r < 58) return ChTwo + 8'(r - 52);
    if (r == 58) return ChZero;
    if (r == 59) return ChOne;
    return ChEight;
  endfunction

  function automatic logic [7:0] pick_skip();
    case ($urandom_range(4))
      0:       return ChNbsp;
      1:       return ChTab;
      2:       return ChLf;
      3:       return ChCr;
      default: return ChPad;
    endcase
  endfunction

  // Characters that fit no class: control codes, punctuation next to the
  // alphabet ranges, '9' and bytes with the top bit set; 0xA0 can come up too and is skipped.
  function automatic logic [7:0] pick_invalid();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'h20;
      2:       return 8'h39;
      3:       return 8'h40;
      4:       return 8'h5B;
      5:       return 8'h60;
      6:       return 8'h7B;
      7:       return 8'h7F;
      8:       return 8'h2F;
      default: return 8'(8'h80 + $urandom_range(8'h7F));
    endcase
  endfunction

  // One random string. Most are well formed with random symbols and a few
  // skipped characters; some carry one invalid character somewhere; a few
  // are short runs of raw bytes.
  task automatic send_string();
    int         mode;
    int         len;
    int         bad_pos;
    int         pos;
    logic [7:0] ch;
    mode    = $urandom_range(99);
    bad_pos = -1;
    if (mode < 8) begin
      len = $urandom_range(1, 3);
    end else begin
      // Mostly short strings, now and then a long one.
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
      if (mode < 25) bad_pos = $urandom_range(len - 1);
    end
    for (pos = 0; pos < len; pos++) begin
      if (mode < 8) begin
        ch = 8'($urandom_range(255));
      end else if (pos == bad_pos) begin
        ch = pick_invalid();
      end else if ($urandom_range(9) == 0) begin
        ch = pick_skip();
      end else begin
        ch = pick_symbol();
      end
      counted_items++;
      send_char(ch, pos == len - 1);
    end
  endtask

  initial begin
    logic paused;
    paused = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every symbol class at its ends, the mistypes, all skipped characters,
    // and a last character that is skipped.
    send_char("A", 1'b0);
    send_char(ChNbsp, 1'b0);
    send_char("Z", 1'b0);
    send_char(ChTab, 1'b0);
    send_char("a", 1'b0);
    send_char(ChLf, 1'b0);
    send_char("z", 1'b0);
    send_char(ChCr, 1'b0);
    send_char("2", 1'b0);
    send_char("7", 1'b0);
    send_char(ChZero, 1'b0);
    send_char(ChOne, 1'b0);
    send_char(ChEight, 1'b0);
    send_char(ChPad, 1'b1);
    // An invalid character mid-string: the flag sticks, the following
    // symbol is dropped, and the string ends on another invalid byte.
    send_char("7", 1'b0);
    send_char("7", 1'b0);
    send_char("@", 1'b0);
    send_char("A", 1'b0);
    send_char(8'hFF, 1'b1);
    // A string of a single invalid byte, one of a lone symbol that leaves
    // only leftover bits, and one whose last character completes a byte.
    send_char(8'h00, 1'b1);
    send_char("A", 1'b1);
    send_char("Q", 1'b0);
    send_char("Q", 1'b1);
    wait_for_results();

    // Random strings. A stretch in the middle runs with no idle cycles on
    // either side, and once the sender holds off until all results are in.
    while (counted_items < RandomItems) begin
      steady = (counted_items >= 600) && (counted_items < 900);
      if (!paused && counted_items >= 1200) begin
        paused = 1'b1;
        wait_for_results();
      end
      send_string();
    end
    steady = 1'b0;

    wait_for_results();
    repeat (TailCycles) @(posedge clk);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("base32_tolerant_decoder: match");
    end else begin
      $display("base32_tolerant_decoder: mismatch");
    end
    $finish;
  end

endmodule
